// ===== hw/rtl/in_order_completion_tracker_top_assert.svh =====
// Assertion macros for the completion tracker checker
`ifndef IN_ORDER_COMPLETION_TRACKER_TOP_ASSERT_SVH
`define IN_ORDER_COMPLETION_TRACKER_TOP_ASSERT_SVH

// checked only outside reset
`define IOCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define IOCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ioct_pkg.sv =====
package ioct_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 11;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] prefix_length;
    logic             all_in_prefix;
    logic [CNT_W-1:0] moment_count;
    logic             bad_position;
  } res_t;

endpackage

// ===== hw/rtl/in_order_completion_tracker_top.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | in_position
// out     | output    | out_valid / out_stall | out_prefix_length, out_all_in_prefix,
//         |           |                       | out_moment_count, out_bad_position
// cfg     | input     | cfg_valid / cfg_ready | cfg_num_entries
//
// After reset all 1024 marks in the RAM are cleared with in_stall high.
// A rejected or held request is answered from the check state; one that extends
// the prefix goes on to a walk that reads one mark after another (the marks walked
// over, then the clear one unless the count stops it) before its result is given.
// A result waits in the output register; the next request is taken meanwhile.
// cfg writes are taken every cycle.
module in_order_completion_tracker_top
  import ioct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CNT_W-1:0] in_position,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CNT_W-1:0] out_prefix_length,
  output logic             out_all_in_prefix,
  output logic [CNT_W-1:0] out_moment_count,
  output logic             out_bad_position,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_num_entries
);

  mem_req_t mem_req;
  logic     mem_rdata;
  logic     res_valid;
  logic     res_ready;
  res_t     res;

  assign cfg_ready = 1'b1;

  ioct_ram #(
    .WIDTH(1),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr),
    .wdata(mem_req.wdata),
    .re   (mem_req.re),
    .raddr(mem_req.raddr),
    .rdata(mem_rdata)
  );

  ioct_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_num_entries),
    .req_valid   (in_valid),
    .req_stall   (in_stall),
    .req_position(in_position),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  ioct_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_prefix_length(out_prefix_length),
    .out_all_in_prefix(out_all_in_prefix),
    .out_moment_count (out_moment_count),
    .out_bad_position (out_bad_position)
  );

endmodule

// ===== hw/rtl/ioct_ram.sv =====
module ioct_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/ioct_seq.sv =====
module ioct_seq
  import ioct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic [CNT_W-1:0] req_position,
  output mem_req_t         mem_req,
  input  logic             mem_rdata,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  st_t               state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]  num_r, num_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  walk_r, walk_nxt;
  logic [CNT_W-1:0]  prefix_r, prefix_nxt;
  logic [CNT_W-1:0]  pend_r, pend_nxt;
  logic [CNT_W-1:0]  moments_r, moments_nxt;

  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  pos_r_m1;
  logic [CNT_W-1:0]  walk_inc;
  logic [CNT_W-1:0]  prefix_inc;
  logic              bad;

  assign n_eff      = (num_r > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : num_r;
  assign pos_m1     = req_position - CNT_W'(1);
  assign pos_r_m1   = pos_r - CNT_W'(1);
  assign walk_inc   = walk_r + CNT_W'(1);
  assign prefix_inc = prefix_r + CNT_W'(1);
  assign bad        = (pos_r == '0) || (pos_r > n_r) || (pos_r <= prefix_r) || mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      num_r      <= CNT_W'(MAX_ENTRIES);
      prefix_r   <= '0;
      pend_r     <= '0;
      moments_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      num_r      <= num_nxt;
      prefix_r   <= prefix_nxt;
      pend_r     <= pend_nxt;
      moments_r  <= moments_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    n_r    <= n_nxt;
    walk_r <= walk_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    num_nxt      = cfg_we ? cfg_data : num_r;
    pos_nxt      = pos_r;
    n_nxt        = n_r;
    walk_nxt     = walk_r;
    prefix_nxt   = prefix_r;
    pend_nxt     = pend_r;
    moments_nxt  = moments_r;

    req_stall     = 1'b1;
    mem_req       = '0;
    res_valid     = 1'b0;
    res.prefix_length = prefix_r;
    res.all_in_prefix = (pend_r == '0);
    res.moment_count  = moments_r;
    res.bad_position  = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr_r;
        clr_addr_nxt  = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          pos_nxt       = req_position;
          n_nxt         = n_eff;
          mem_req.re    = 1'b1;
          mem_req.raddr = pos_m1[ADDR_W-1:0];
          state_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (bad) begin
          res.bad_position = 1'b1;
          if (res_ready) begin
            res_valid = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (pos_r == prefix_inc) begin
          walk_nxt = pos_r;
          if (pos_r < n_r) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = pos_r[ADDR_W-1:0];
            state_nxt     = ST_WALK;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          res.all_in_prefix = 1'b0;
          if (res_ready) begin
            // hold as pending
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_r_m1[ADDR_W-1:0];
            mem_req.wdata = 1'b1;
            pend_nxt      = pend_r + CNT_W'(1);
            res_valid     = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_WALK: begin
        if (mem_rdata) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = walk_r[ADDR_W-1:0];
          walk_nxt      = walk_inc;
          if (pend_r != '0) begin
            pend_nxt = pend_r - CNT_W'(1);
          end
          if (walk_inc < n_r) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = walk_inc[ADDR_W-1:0];
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        res.prefix_length = walk_r;
        res.moment_count  = (pend_r == '0) ? moments_r + CNT_W'(1) : moments_r;
        if (res_ready) begin
          res_valid   = 1'b1;
          prefix_nxt  = walk_r;
          moments_nxt = res.moment_count;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ioct_out.sv =====
module ioct_out
  import ioct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  output logic             res_ready,
  input  res_t             res,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CNT_W-1:0] out_prefix_length,
  output logic             out_all_in_prefix,
  output logic [CNT_W-1:0] out_moment_count,
  output logic             out_bad_position
);

  logic out_valid_r, out_valid_nxt;
  res_t res_r, res_nxt;

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_prefix_length = res_r.prefix_length;
  assign out_all_in_prefix = res_r.all_in_prefix;
  assign out_moment_count  = res_r.moment_count;
  assign out_bad_position  = res_r.bad_position;

endmodule

// ===== hw/rtl/ioct_chk.sv =====
`include "in_order_completion_tracker_top_assert.svh"

module ioct_chk
  import ioct_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CNT_W-1:0] out_prefix_length,
  input logic             out_all_in_prefix,
  input logic [CNT_W-1:0] out_moment_count,
  input logic             out_bad_position
);

  logic [2*CNT_W+1:0] out_payload;

  assign out_payload = {out_prefix_length, out_all_in_prefix, out_moment_count,
                        out_bad_position};

  `IOCT_ASSERT_ALWAYS(a_rst_no_out, !rst_n |=> !out_valid, "result valid after reset")
  `IOCT_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> in_stall, "request taken during clear")
  `IOCT_ASSERT(a_one_at_a_time, in_valid && !in_stall |=> in_stall, "second request too soon")
  `IOCT_ASSERT(a_prefix_range, out_valid |-> out_prefix_length <= CNT_W'(MAX_ENTRIES), "prefix too long")
  `IOCT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_payload), "stalled result changed")

endmodule

bind in_order_completion_tracker_top ioct_chk u_chk (.*);

// ===== tb/sv/in_order_completion_tracker_top_test.sv =====
`timescale 1ns / 1ps

module in_order_completion_tracker_top_test;
  import ioct_pkg::*;

  typedef enum logic [1:0] {
    PLAN_REQUEST,
    PLAN_COUNT,
    PLAN_WAIT
  } plan_kind_t;

  typedef struct {
    plan_kind_t       kind;
    logic [CNT_W-1:0] value;
  } plan_step_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CNT_W-1:0] in_position = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CNT_W-1:0] out_prefix_length;
  logic             out_all_in_prefix;
  logic [CNT_W-1:0] out_moment_count;
  logic             out_bad_position;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_num_entries = '0;

  in_order_completion_tracker_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_prefix_length(out_prefix_length),
    .out_all_in_prefix(out_all_in_prefix),
    .out_moment_count (out_moment_count),
    .out_bad_position (out_bad_position),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_num_entries  (cfg_num_entries)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tracker state as predicted
  bit               held_mark [1:MAX_ENTRIES];
  int unsigned      done_len = 0;
  int unsigned      held_total = 0;
  logic [CNT_W-1:0] moment_tally = '0;
  logic [CNT_W-1:0] entry_limit = 11'd1024;

  res_t             predicted_status[$];
  plan_step_t       request_plan[$];
  int               plan_window[$];

  int unsigned      positions_sent = 0;
  int unsigned      status_seen = 0;
  int               mismatches = 0;
  logic             quiet = 1'b0;
  int               send_gap = 0;
  int               sink_gap = 0;
  int               send_odds = 10;
  int               sink_odds = 10;
  logic             next_in_valid;
  logic             next_cfg_valid;
  logic [CNT_W-1:0] next_position;
  logic [CNT_W-1:0] next_count;
  res_t             want_status;

  task automatic mark_complete(input logic [CNT_W-1:0] pos);
    int unsigned lim;
    int unsigned p;
    logic        rejected;
    res_t        r;
    lim = (entry_limit > MAX_ENTRIES) ? MAX_ENTRIES : entry_limit;
    rejected = (pos == 0) || (pos > lim) || (pos <= done_len) || held_mark[pos];
    if (!rejected) begin
      if (pos == done_len + 1) begin
        p = pos;
        while (p < lim && held_mark[p + 1]) begin
          p++;
          held_mark[p] = 1'b0;
          if (held_total > 0) held_total--;
        end
        done_len = p;
        if (held_total == 0) moment_tally++;
      end else begin
        held_mark[pos] = 1'b1;
        held_total++;
      end
    end
    r.prefix_length = done_len[CNT_W-1:0];
    r.all_in_prefix = (held_total == 0);
    r.moment_count  = moment_tally;
    r.bad_position  = rejected;
    predicted_status.push_back(r);
  endtask

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want)
      note_failure($sformatf("%s: expected %0d, got %0d", name, want, got));
  endtask

  function automatic int idle_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 6;
      default: return 30;
    endcase
  endfunction

  task automatic push_step(input plan_kind_t kind, input int value);
    plan_step_t s;
    s.kind  = kind;
    s.value = value[CNT_W-1:0];
    request_plan.push_back(s);
  endtask

  // a position certain to be rejected: zero, done, already sent, or beyond the count
  function automatic logic [CNT_W-1:0] stale_position(input int base, input int lim,
                                                      input int upto);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CNT_W'($urandom_range(1, base));
      2: begin
        if (upto > 0) return CNT_W'(plan_window[$urandom_range(0, upto - 1)]);
        else return '0;
      end
      default: return CNT_W'($urandom_range(lim + 1, 2047));
    endcase
  endfunction

  task automatic queue_window(input int first, input int span, input int lim);
    int j;
    int k;
    int tmp;
    int style;
    plan_window.delete();
    style = $urandom_range(0, 3);
    for (j = 0; j < span; j++)
      plan_window.push_back((style == 1) ? first + span - 1 - j : first + j);
    if (style >= 2) begin
      for (j = span - 1; j > 0; j--) begin
        k = $urandom_range(0, j);
        tmp = plan_window[j];
        plan_window[j] = plan_window[k];
        plan_window[k] = tmp;
      end
    end
    for (j = 0; j < span; j++) begin
      while ($urandom_range(0, 7) < 3)
        push_step(PLAN_REQUEST, stale_position(first - 1, lim, j));
      push_step(PLAN_REQUEST, plan_window[j]);
    end
  endtask

  always @(posedge clk) begin
    next_in_valid  = 1'b0;
    next_cfg_valid = 1'b0;
    next_position  = in_position;
    next_count     = cfg_num_entries;
    if (!rst_n) begin
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        mark_complete(in_position);
        positions_sent <= positions_sent + 1;
      end
      if (cfg_valid && cfg_ready) entry_limit = cfg_num_entries;
      if ($urandom_range(0, 63) == 0) send_odds = idle_odds();
      if ((in_valid && in_stall) || (cfg_valid && !cfg_ready)) begin
        next_in_valid  = in_valid;
        next_cfg_valid = cfg_valid;
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
      end else if (!quiet && $urandom_range(0, 99) < send_odds) begin
        send_gap <= $urandom_range(0, 18);
      end else if (request_plan.size() != 0) begin
        case (request_plan[0].kind)
          PLAN_REQUEST: begin
            next_in_valid = 1'b1;
            next_position = request_plan[0].value;
            void'(request_plan.pop_front());
          end
          PLAN_COUNT: begin
            if (positions_sent == status_seen && !in_valid) begin
              next_cfg_valid = 1'b1;
              next_count     = request_plan[0].value;
              void'(request_plan.pop_front());
            end
          end
          default: begin
            if (positions_sent == status_seen && !in_valid) void'(request_plan.pop_front());
          end
        endcase
      end
      quiet <= (request_plan.size() < 150);
    end
    in_valid        <= next_in_valid;
    in_position     <= next_position;
    cfg_valid       <= next_cfg_valid;
    cfg_num_entries <= next_count;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_gap  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        status_seen <= status_seen + 1;
        if (predicted_status.size() == 0) begin
          note_failure("result with no request outstanding");
        end else begin
          want_status = predicted_status.pop_front();
          check_field("prefix_length", want_status.prefix_length, out_prefix_length);
          check_field("all_in_prefix", CNT_W'(want_status.all_in_prefix),
                      CNT_W'(out_all_in_prefix));
          check_field("moment_count", want_status.moment_count, out_moment_count);
          check_field("bad_position", CNT_W'(want_status.bad_position),
                      CNT_W'(out_bad_position));
        end
      end
      if ($urandom_range(0, 63) == 0) sink_odds = idle_odds();
      if (sink_gap != 0) begin
        sink_gap  <= sink_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < sink_odds) begin
        sink_gap  <= $urandom_range(0, 18);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int   base;
    int   lim;
    int   span;
    int   value;
    logic recount;

    // reset count of 1024 in force
    push_step(PLAN_REQUEST, 0);
    push_step(PLAN_REQUEST, 2047);
    push_step(PLAN_REQUEST, 1025);
    push_step(PLAN_REQUEST, 3);
    push_step(PLAN_REQUEST, 3);
    push_step(PLAN_REQUEST, 2);
    push_step(PLAN_REQUEST, 1);
    push_step(PLAN_REQUEST, 2);
    push_step(PLAN_REQUEST, 4);
    push_step(PLAN_REQUEST, 7);
    push_step(PLAN_COUNT, 1);
    push_step(PLAN_REQUEST, 5);
    push_step(PLAN_REQUEST, 1);
    // walk stops at the count, 7 still held
    push_step(PLAN_COUNT, 5);
    push_step(PLAN_REQUEST, 5);
    push_step(PLAN_REQUEST, 6);
    push_step(PLAN_REQUEST, MAX_ENTRIES);
    push_step(PLAN_COUNT, 0);
    push_step(PLAN_REQUEST, 6);
    push_step(PLAN_REQUEST, 1);
    // saturates; 6 then walks over 7
    push_step(PLAN_COUNT, 2047);
    push_step(PLAN_REQUEST, 6);
    push_step(PLAN_REQUEST, 2047);
    push_step(PLAN_REQUEST, 8);

    base = 8;
    lim  = MAX_ENTRIES;
    while (base < 1000) begin
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      if (base + span > 1000) span = 1000 - base;
      value   = $urandom_range(0, 7);
      recount = (value < 3) || (lim < base + span);
      if (value == 3) push_step(PLAN_WAIT, 0);
      if (recount) begin
        case ($urandom_range(0, 4))
          0: value = 2047;
          1: value = MAX_ENTRIES;
          2: value = base + span;
          3: value = $urandom_range(base + span, MAX_ENTRIES);
          default: value = $urandom_range(MAX_ENTRIES + 1, 2047);
        endcase
        push_step(PLAN_COUNT, value);
        lim = (value > MAX_ENTRIES) ? MAX_ENTRIES : value;
      end
      queue_window(base + 1, span, lim);
      base += span;
    end

    // top entry held beyond a reduced count; the walk must stop short of it
    push_step(PLAN_COUNT, MAX_ENTRIES);
    push_step(PLAN_REQUEST, MAX_ENTRIES);
    push_step(PLAN_COUNT, MAX_ENTRIES - 1);
    queue_window(1001, 23, MAX_ENTRIES - 1);
    push_step(PLAN_COUNT, MAX_ENTRIES);
    push_step(PLAN_REQUEST, MAX_ENTRIES);
    push_step(PLAN_REQUEST, MAX_ENTRIES - 1);
    push_step(PLAN_REQUEST, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (request_plan.size() != 0 || in_valid || cfg_valid ||
           positions_sent != status_seen)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0)
      $display("PASS in_order_completion_tracker_top");
    else
      $display("FAIL in_order_completion_tracker_top");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL in_order_completion_tracker_top");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ioct_pkg.sv
hw/rtl/ioct_ram.sv
hw/rtl/ioct_seq.sv
hw/rtl/ioct_out.sv
hw/rtl/in_order_completion_tracker_top.sv
hw/rtl/ioct_chk.sv
tb/sv/in_order_completion_tracker_top_test.sv
